FILE: sv/gnt_pkg.sv
// Shared types, constants and constant tables of the gradient noise terrain core.
// Depends on nothing; every module of the block imports it.
package gnt_pkg;

	localparam int CHUNK_SIDE   = 16;
	localparam int WORLD_HEIGHT = 256;
	localparam int HEIGHT_CAP   = (WORLD_HEIGHT < 256) ? WORLD_HEIGHT : 256;
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

	localparam logic [31:0] HASH_KX = 32'd374761393;
	localparam logic [31:0] HASH_KZ = 32'd668265263;
	localparam logic [31:0] HASH_KM = 32'd1274126177;
	// floor(2^35 / 45): quotient estimate for the modulo 45 step.
	localparam logic [29:0] MOD45_RECIP = 30'd763549741;

	typedef logic [14:0] sin_tab_t [0:90];
	typedef logic [14:0] fade_tab_t [0:15];

	typedef enum logic [1:0] {
		PIECE_LOW,
		PIECE_MID,
		PIECE_HIGH
	} piece_t;

	// Gradients of the four lattice corners plus the cell position.
	typedef struct packed {
		logic [3:0][15:0] gc;
		logic [3:0][15:0] gs;
		logic [3:0]       col;
		logic [3:0]       row;
	} gnt_item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} gnt_fifo_stat_t;

	// Sine in Q1.14 for whole degrees, built by repeated one degree rotations in Q30.
	function automatic sin_tab_t build_sin_tab();
		longint c;
		longint s;
		longint nc;
		longint ns;
		longint q;
		sin_tab_t t;
		c = 64'sd1 <<< 30;
		s = 64'sd0;
		for (int d = 0; d <= 90; d++) begin
			q = (s + 64'sd32768) >>> 16;
			if (q > 64'sd16384)
				q = 64'sd16384;
			t[d] = 15'(q);
			if (d < 90) begin
				nc = c * 64'sd1073578288 - s * 64'sd18739379;
				ns = s * 64'sd1073578288 + c * 64'sd18739379;
				if (nc < 0)
					nc = 0;
				c = (nc + (64'sd1 <<< 29)) >>> 30;
				s = (ns + (64'sd1 <<< 29)) >>> 30;
			end
		end
		return t;
	endfunction

	// Quintic fade of (2c+1)/32, rounded half up to Q14.
	function automatic fade_tab_t build_fade_tab();
		longint m;
		longint num;
		fade_tab_t t;
		for (int c = 0; c < 16; c++) begin
			m = 2 * c + 1;
			num = m * m * m * (6 * m * m + 10240 - 480 * m);
			t[c] = 15'((num + 1024) >>> 11);
		end
		return t;
	endfunction

	localparam sin_tab_t  SIN_TAB  = build_sin_tab();
	localparam fade_tab_t FADE_TAB = build_fade_tab();

endpackage

FILE: sv/gnt_front.sv
// Front part: hashes the seed with the four lattice corners and looks up the gradients.
// Five pipeline stages, never stalls; depends on gnt_pkg.
module gnt_front import gnt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     seed,
	input  logic            in_valid,
	input  logic [31:0]     corner_x,
	input  logic [31:0]     corner_z,
	input  logic [3:0]      cell_col,
	input  logic [3:0]      cell_row,
	output logic            item_valid,
	output gnt_item_t       item
);

	logic [31:0] x1, z1;
	logic [1:0][31:0] px_s1, pz_s1;
	logic [3:0] col_s1, row_s1, col_s2, row_s2, col_s3, row_s3, col_s4, row_s4;
	logic [3:0][31:0] m_s2;
	logic [3:0][23:0] q_s3;
	logic [3:0][28:0] n_s3;
	logic [3:0][2:0]  lo_s3;
	logic [3:0][8:0]  ang_s4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	gnt_item_t item_s5;

	logic [3:0][31:0] m_d;
	logic [3:0][23:0] q_d;
	logic [3:0][28:0] n_d;
	logic [3:0][2:0]  lo_d;
	logic [3:0][8:0]  ang_d;
	logic [3:0][15:0] gc_d, gs_d;

	assign x1 = corner_x + 32'(CHUNK_SIDE);
	assign z1 = corner_z + 32'(CHUNK_SIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		logic [31:0] h;
		logic [31:0] g;
		logic [31:0] h2;
		logic [58:0] prod;
		logic [29:0] qm;
		logic [29:0] rr;
		logic [6:0]  r7;
		logic [5:0]  r6;
		logic [8:0]  a;
		logic [6:0]  r;
		logic [15:0] sr;
		logic [15:0] cr;
		for (int i = 0; i < 4; i++) begin
			h = seed ^ px_s1[i % 2] ^ pz_s1[i / 2];
			g = h ^ (h >> 13);
			m_d[i] = g * HASH_KM;

			h2 = m_s2[i] ^ (m_s2[i] >> 16);
			n_d[i] = h2[31:3];
			lo_d[i] = h2[2:0];
			prod = 59'(h2[31:3]) * 59'(MOD45_RECIP);
			q_d[i] = prod[58:35];

			// The quotient estimate is low by at most one, so one correction suffices.
			qm = 30'(q_s3[i]) * 30'd45;
			rr = {1'b0, n_s3[i]} - qm;
			r7 = rr[6:0];
			r6 = (r7 >= 7'd45) ? 6'(r7 - 7'd45) : r7[5:0];
			ang_d[i] = {r6, lo_s3[i]};

			a = ang_s4[i];
			if (a < 9'd90)
				r = a[6:0];
			else if (a < 9'd180)
				r = 7'(a - 9'd90);
			else if (a < 9'd270)
				r = 7'(a - 9'd180);
			else
				r = 7'(a - 9'd270);
			sr = {1'b0, SIN_TAB[r]};
			cr = {1'b0, SIN_TAB[7'd90 - r]};
			if (a < 9'd90) begin
				gc_d[i] = cr;
				gs_d[i] = sr;
			end else if (a < 9'd180) begin
				gc_d[i] = -sr;
				gs_d[i] = cr;
			end else if (a < 9'd270) begin
				gc_d[i] = -cr;
				gs_d[i] = -sr;
			end else begin
				gc_d[i] = sr;
				gs_d[i] = -cr;
			end
		end
	end

	always_ff @(posedge clk) begin
		px_s1[0] <= corner_x * HASH_KX;
		px_s1[1] <= x1 * HASH_KX;
		pz_s1[0] <= corner_z * HASH_KZ;
		pz_s1[1] <= z1 * HASH_KZ;
		col_s1 <= cell_col;
		row_s1 <= cell_row;
		m_s2 <= m_d;
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		q_s3 <= q_d;
		n_s3 <= n_d;
		lo_s3 <= lo_d;
		col_s3 <= col_s2;
		row_s3 <= row_s2;
		ang_s4 <= ang_d;
		col_s4 <= col_s3;
		row_s4 <= row_s3;
		item_s5.gc <= gc_d;
		item_s5.gs <= gs_d;
		item_s5.col <= col_s4;
		item_s5.row <= row_s4;
	end

	assign item_valid = v_s5;
	assign item = item_s5;

endmodule

FILE: sv/gnt_fifo.sv
// Short queue of gradient items between the front and back parts.
// Register based, one write and one read a cycle; depends on gnt_pkg.
module gnt_fifo import gnt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gnt_item_t      wr_item,
	input  logic           pop,
	output gnt_item_t      rd_item,
	output gnt_fifo_stat_t stat
);

	gnt_item_t mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= FIFO_AW'(wr_q + 1'b1);
			if (pop)
				rd_q <= FIFO_AW'(rd_q + 1'b1);
			cnt_q <= FIFO_CW'(cnt_q + FIFO_CW'(push) - FIFO_CW'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_item;
	end

	assign rd_item = mem_q[rd_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full = (cnt_q == FIFO_CW'(FIFO_DEPTH));

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.valid) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: sv/gnt_back.sv
// Back part: dot products, fade interpolation, noise rounding and the height curve.
// Stalls as a whole when the output register is full and out_ready is low; depends on gnt_pkg.
module gnt_back import gnt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  gnt_item_t      item,
	input  gnt_fifo_stat_t stat,
	output logic           pop,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [14:0]    noise_plus_one,
	output logic [8:0]     column_height
);

	logic ce;
	logic v_b1, v_b2, v_b3, v_b4, v_b5, out_valid_q;
	logic signed [31:0] d_b1 [4];
	logic [3:0] col_b1, row_b1;
	logic signed [47:0] ix0_b2, ix1_b2;
	logic [14:0] v_fade_b2;
	logic signed [63:0] val_b3;
	logic [14:0] p_b4, p_b5;
	logic [25:0] sq_b5;
	piece_t piece_b5;
	logic [14:0] noise_q;
	logic [8:0] height_q;

	logic signed [31:0] d_d [4];
	logic signed [47:0] ix0_d, ix1_d;
	logic signed [63:0] val_d;
	logic [14:0] p_d;
	logic [25:0] sq_d;
	piece_t piece_d;
	logic [8:0] height_d;

	assign ce = !out_valid_q || out_ready;
	assign pop = ce && stat.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (ce) begin
			v_b1 <= stat.valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
			out_valid_q <= v_b5;
		end
	end

	// Dot products of the corner gradients with the Q14 offsets.
	always_comb begin
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dxm;
		logic signed [15:0] dym;
		dx = {2'b00, item.col, 1'b1, 9'b0};
		dy = {2'b00, item.row, 1'b1, 9'b0};
		dxm = dx - 16'sd16384;
		dym = dy - 16'sd16384;
		d_d[0] = $signed(item.gc[0]) * dx  + $signed(item.gs[0]) * dy;
		d_d[1] = $signed(item.gc[1]) * dxm + $signed(item.gs[1]) * dy;
		d_d[2] = $signed(item.gc[2]) * dx  + $signed(item.gs[2]) * dym;
		d_d[3] = $signed(item.gc[3]) * dxm + $signed(item.gs[3]) * dym;
	end

	always_comb begin
		logic signed [15:0] su;
		logic signed [32:0] df0;
		logic signed [32:0] df1;
		logic signed [47:0] a0;
		logic signed [47:0] a1;
		logic signed [47:0] m0;
		logic signed [47:0] m1;
		su = {1'b0, FADE_TAB[col_b1]};
		df0 = d_b1[1] - d_b1[0];
		df1 = d_b1[3] - d_b1[2];
		a0 = d_b1[0];
		a1 = d_b1[2];
		m0 = su * df0;
		m1 = su * df1;
		ix0_d = (a0 <<< 14) + m0;
		ix1_d = (a1 <<< 14) + m1;
	end

	always_comb begin
		logic signed [15:0] sv_;
		logic signed [48:0] df;
		logic signed [63:0] base;
		logic signed [63:0] m;
		sv_ = {1'b0, v_fade_b2};
		df = ix1_b2 - ix0_b2;
		base = ix0_b2;
		m = sv_ * df;
		val_d = (base <<< 14) + m + (64'sd1 <<< 56);
	end

	// Round half up to Q14, clamp at zero and at the top code.
	always_comb begin
		logic signed [63:0] r;
		r = (val_b3 + (64'sd1 <<< 41)) >>> 42;
		if (val_b3 < 0)
			p_d = '0;
		else if (r > 64'sd32767)
			p_d = 15'h7fff;
		else
			p_d = r[14:0];
	end

	always_comb begin
		logic [12:0] e;
		if (p_b4 < 15'd8192) begin
			piece_d = PIECE_LOW;
			e = p_b4[12:0];
		end else if (p_b4 < 15'd24576) begin
			piece_d = PIECE_MID;
			e = '0;
		end else begin
			piece_d = PIECE_HIGH;
			e = 13'(p_b4 - 15'd24576);
		end
		sq_d = 26'(e) * 26'(e);
	end

	// Limits are rounded up to whole levels.
	always_comb begin
		logic [33:0] t;
		logic [14:0] pm;
		logic [9:0]  lim;
		t = '0;
		pm = '0;
		case (piece_b5)
			PIECE_LOW: begin
				t = 34'(sq_b5) * 34'd40 + 34'((1 << 26) - 1);
				lim = 10'd80 + 10'(t >> 26);
			end
			PIECE_MID: begin
				pm = 15'(p_b5 - 15'd8192 + 15'd1023);
				lim = 10'd120 + 10'(pm >> 10);
			end
			PIECE_HIGH: begin
				t = 34'(sq_b5) * 34'd114 + 34'((1 << 26) - 1);
				lim = 10'd136 + 10'(t >> 26);
			end
			default: lim = 10'd0;
		endcase
		if (lim > 10'(HEIGHT_CAP))
			lim = 10'(HEIGHT_CAP);
		height_d = lim[8:0];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_b1 <= d_d;
			col_b1 <= item.col;
			row_b1 <= item.row;
			ix0_b2 <= ix0_d;
			ix1_b2 <= ix1_d;
			v_fade_b2 <= FADE_TAB[row_b1];
			val_b3 <= val_d;
			p_b4 <= p_d;
			p_b5 <= p_b4;
			sq_b5 <= sq_d;
			piece_b5 <= piece_d;
			noise_q <= p_b5;
			height_q <= height_d;
		end
	end

	assign out_valid = out_valid_q;
	assign noise_plus_one = noise_q;
	assign column_height = height_q;

endmodule

FILE: sv/gradient_noise_terrain_height_core.sv
// Top level of the gradient noise terrain core: seed register, queue credit and wiring.
// Depends on gnt_pkg, gnt_front, gnt_fifo and gnt_back.
//
// Usage:
// The s_ channel carries one column request per transfer; the m_ channel returns one
// result per request, in request order. The cfg_ channel writes the 32 bit seed and
// is always ready; write it only while no request is in flight.
// Throughput is one column per cycle while m_tready stays high: the front hash pipeline
// has five stages and the back pipeline six, and neither holds a loop.
// Input ready is a credit on the eight entry queue between the two parts: a request
// is taken only while the queue can hold every request not yet read by the back part.
// When the receiver stalls, the back pipeline holds, the queue fills, and s_tready
// falls once the credits are used up; nothing is lost.
// Reset clears the seed to zero and empties both pipelines and the queue.
module gradient_noise_terrain_height_core import gnt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// corner_x [31:0], corner_z [63:32], cell_col [67:64], cell_row [71:68]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// noise_plus_one [14:0], column_height [23:15]
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] seed_q;
	logic [FIFO_CW-1:0] credit_q;
	logic in_xfer;
	logic front_valid;
	gnt_item_t front_item;
	gnt_item_t fifo_item;
	gnt_fifo_stat_t fifo_stat;
	logic pop;
	logic [14:0] noise;
	logic [8:0] height;

	assign cfg_ready = 1'b1;
	assign s_tready = (credit_q < FIFO_CW'(FIFO_DEPTH));
	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			credit_q <= '0;
		end else begin
			if (cfg_valid)
				seed_q <= cfg_data;
			credit_q <= FIFO_CW'(credit_q + FIFO_CW'(in_xfer) - FIFO_CW'(pop));
		end
	end

	gnt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.in_valid   (in_xfer),
		.corner_x   (s_tdata[31:0]),
		.corner_z   (s_tdata[63:32]),
		.cell_col   (s_tdata[67:64]),
		.cell_row   (s_tdata[71:68]),
		.item_valid (front_valid),
		.item       (front_item)
	);

	gnt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_valid),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (fifo_item),
		.stat    (fifo_stat)
	);

	gnt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (fifo_item),
		.stat           (fifo_stat),
		.pop            (pop),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.noise_plus_one (noise),
		.column_height  (height)
	);

	assign m_tdata = {height, noise};

endmodule
